### rtl/bslm_pkg.sv
// ============================================================================
// Block signal level meter package
// Shared widths, register codes and the log2 fraction table of the meter.
// ============================================================================
package bslm_pkg;

    // Configuration port widths and register indexes.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SKIP_COUNT = 8'd0,
        CFG_REF_DB     = 8'd1
    } cfg_reg_t;

    // Level to dB conversion widths.
    localparam int X_W      = 9;           // ceil(level*508/FS), 1..508
    localparam int XN_W     = 4;           // integer part of log2(x), 0..8
    localparam int FRAC_W   = 20;          // fraction bits of log2(x)
    localparam int LOG_W    = XN_W + FRAC_W;
    localparam int COEF_W   = 27;
    localparam int PROD_W   = LOG_W + COEF_W;
    localparam int DB_SHIFT = 40;
    localparam int DB_W     = 10;          // Q4 dB before reference, 0..866
    localparam int DBO_W    = 13;          // signed Q4 dB after reference
    localparam int S_W      = 8;           // Q4 dB divided by six
    localparam int X_SCALE  = 508;

    // 320*log10(2) in Q20 and the half-LSB rounding term.
    localparam logic [COEF_W-1:0] DB_COEF  = 27'd101008905;
    localparam logic [PROD_W-1:0] DB_ROUND = PROD_W'(1) << (DB_SHIFT - 1);

    // Division by six as a reciprocal multiply, exact for values below 2^DB_W.
    localparam int                 S_RECIP_W = 11;
    localparam logic [S_RECIP_W-1:0] S_RECIP = 11'd1366;
    localparam int                 S_SHIFT   = 13;
    localparam int                 S_PROD_W  = DB_W + S_RECIP_W;

    // Fraction of log2 for normalized mantissas 256..511, indexed by the
    // low eight bits. Built by truncated repeated squaring of a Q30 mantissa.
    localparam int TAB_DEPTH = 256;
    typedef logic [FRAC_W-1:0] frac_tab_t [TAB_DEPTH];

    function automatic frac_tab_t build_frac_tab();
        frac_tab_t   tab;
        logic [63:0] m;
        logic [FRAC_W-1:0] f;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            m = 64'(TAB_DEPTH + i) << 22;
            f = '0;
            for (int j = 0; j < FRAC_W; j++) begin
                m = (m * m) >> 30;
                f = f << 1;
                if (m >= (64'd2 << 30)) begin
                    m    = m >> 1;
                    f[0] = 1'b1;
                end
            end
            tab[i] = f;
        end
        return tab;
    endfunction

    localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage

### rtl/bslm_ram.sv
// ============================================================================
// Block signal level meter RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module bslm_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/block_signal_level_meter_top.sv
// ============================================================================
// Block signal level meter
// Tracks per-block peak and floor of sample magnitudes, averages recent block
// peaks over a ring, and reports levels with Q4 dB and S values.
// ============================================================================
//
// Channel  Dir  Handshake              Payload
// -------  ---  ---------------------  -------------------------------------
// s_       in   s_tvalid / s_tready    s_tdata: sample; s_tlast: block_end
// m_       out  m_tvalid / m_tready    m_tdata: levels, dB and S values
// cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// One sample is accepted per cycle while the result pipeline is not stalled. A
// measured block's result passes through the input register, state update,
// two stages for the ring average multiply, level scaling, log2 table and
// the dB multiply, then the S multiply into the output register.
// Reset is synchronous, active low, and clears all control and meter state;
// ring entries read as zero until written through per-entry valid bits.
// A stalled result holds the output register while empty pipeline stages
// keep taking samples until the stall reaches the input register.
//
module block_signal_level_meter_top
    import bslm_pkg::*;
#(
    parameter int AVG_LEN     = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Fields from bit 0: sample.
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    input  logic                                  s_tlast,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: peak_level, floor_level, average_level, peak_db,
    // average_db, peak_s, average_s.
    output logic [((3*(SAMPLE_BITS-1)+2*DBO_W+2*S_W+7)/8)*8-1:0] m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [CFG_DATA_W-1:0]                 cfg_data
);

    // Derived widths and constants.
    localparam int LW       = SAMPLE_BITS - 1;
    localparam int OUT_BITS = 3 * LW + 2 * DBO_W + 2 * S_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int POS_W    = $clog2(AVG_LEN);
    localparam int SUM_W    = LW + POS_W;
    localparam int CNT_W    = 8;

    localparam logic [LW-1:0] FULL_SCALE = '1;
    localparam longint        FS_L       = (longint'(1) << LW) - 1;
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(longint'(AVG_LEN) * FS_L);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVG_LEN - 1);

    // Ring mean as a reciprocal multiply, split into two partial products.
    localparam int          AVG_L  = $clog2(AVG_LEN);
    localparam int          AVG_K  = SUM_W + AVG_L;
    localparam int          AVG_MW = SUM_W + 1;
    localparam int          AVG_H  = (AVG_MW + 1) / 2;
    localparam logic [63:0] AVG_M  =
        ((64'd1 << AVG_K) + 64'(AVG_LEN) - 64'd1) / 64'(AVG_LEN);
    localparam logic [AVG_H-1:0]        AVG_M_LO = AVG_M[AVG_H-1:0];
    localparam logic [AVG_MW-AVG_H-1:0] AVG_M_HI = AVG_M[AVG_MW-1:AVG_H];
    localparam int PLO_W = SUM_W + AVG_H;
    localparam int PHI_W = SUM_W + AVG_MW - AVG_H;
    localparam int PTOT_W = SUM_W + AVG_MW;

    // Level scaling: num = level*508 + FS - 1 folded against FS = 2^LW - 1.
    localparam int NUM_W = LW + 10;
    localparam int Q_W   = 10;
    localparam int UW    = ((LW > 10) ? LW : 10) + 1;
    localparam int X_J   = int'((longint'(X_SCALE) + FS_L) / FS_L);

    // ------------------------------------------------------------------
    // Helper functions
    // ------------------------------------------------------------------

    // ceil(level*508/FS), with zero mapped to one.
    function automatic logic [X_W-1:0] lvl_to_x(input logic [LW-1:0] lvl);
        logic [NUM_W-1:0] num;
        logic [Q_W-1:0]   t;
        logic [UW-1:0]    u;
        logic [Q_W-1:0]   q;
        num = NUM_W'(lvl) * NUM_W'(X_SCALE) + NUM_W'(FULL_SCALE - 1'b1);
        t   = num[NUM_W-1 -: Q_W];
        u   = UW'(t) + UW'(num[LW-1:0]);
        q   = t;
        for (int j = 1; j <= X_J; j++) begin
            if (u >= UW'(longint'(j) * FS_L)) begin
                q = q + 1'b1;
            end
        end
        if (q == '0) begin
            q = Q_W'(1);
        end
        return q[X_W-1:0];
    endfunction

    // log2(x) in Q20: integer part by priority encode, fraction by table.
    function automatic logic [LOG_W-1:0] x_log2(input logic [X_W-1:0] x);
        logic [XN_W-1:0] n;
        logic [X_W-1:0]  v;
        n = '0;
        for (int b = 0; b < X_W; b++) begin
            if (x[b]) begin
                n = XN_W'(b);
            end
        end
        v = x << (XN_W'(X_W - 1) - n);
        return {n, FRAC_TAB[v[X_W-2:0]]};
    endfunction

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]      skip_count_reg;
    logic [CFG_DATA_W-1:0] ref_db_reg;

    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   in_last_reg;

    logic [CNT_W-1:0]   block_counter_reg, block_counter_next;
    logic [LW-1:0]      running_peak_reg, running_peak_next;
    logic [LW-1:0]      running_floor_reg, running_floor_next;
    logic [AVG_LEN-1:0] ring_valid_reg, ring_valid_next;
    logic [POS_W-1:0]   ring_pos_reg, ring_pos_next;
    logic [SUM_W-1:0]   ring_sum_reg, ring_sum_next;

    logic [SAMPLE_BITS-1:0] mag_raw;
    logic [LW-1:0]          mag;
    logic [LW-1:0]          blk_peak;
    logic [LW-1:0]          blk_floor;
    logic [LW-1:0]          ring_old;
    logic [LW-1:0]          ram_rd_data;
    logic                   ram_wr_en;
    logic                   fire_a;
    logic                   meas_evt;

    logic rdy_out, rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    logic             st1_valid_reg;
    logic [LW-1:0]    st1_peak_reg, st1_floor_reg;
    logic [SUM_W-1:0] st1_sum_reg;
    logic [PLO_W-1:0] st2_pp_lo_next;
    logic [PHI_W-1:0] st2_pp_hi_next;

    logic             st2_valid_reg;
    logic [LW-1:0]    st2_peak_reg, st2_floor_reg;
    logic [PLO_W-1:0] st2_pp_lo_reg;
    logic [PHI_W-1:0] st2_pp_hi_reg;
    logic [PTOT_W-1:0] avg_total;
    logic [LW-1:0]    st3_avg_next;

    logic             st3_valid_reg;
    logic [LW-1:0]    st3_peak_reg, st3_floor_reg, st3_avg_reg;
    logic [X_W-1:0]   st4_xp_next, st4_xa_next;

    logic             st4_valid_reg;
    logic [LW-1:0]    st4_peak_reg, st4_floor_reg, st4_avg_reg;
    logic [X_W-1:0]   st4_xp_reg, st4_xa_reg;
    logic [LOG_W-1:0] st5_lp_next, st5_la_next;

    logic             st5_valid_reg;
    logic [LW-1:0]    st5_peak_reg, st5_floor_reg, st5_avg_reg;
    logic [LOG_W-1:0] st5_lp_reg, st5_la_reg;
    logic [PROD_W-1:0] db_prod_p, db_prod_a;
    logic [DB_W-1:0]  st6_dbp_next, st6_dba_next;

    logic             st6_valid_reg;
    logic [LW-1:0]    st6_peak_reg, st6_floor_reg, st6_avg_reg;
    logic [DB_W-1:0]  st6_dbp_reg, st6_dba_reg;
    logic [S_PROD_W-1:0] s_prod_p, s_prod_a;
    logic [DBO_W-1:0] ref_q4;
    logic [DBO_W-1:0] out_dbp_next, out_dba_next;
    logic [S_W-1:0]   out_sp_next, out_sa_next;

    logic             out_valid_reg;
    logic [LW-1:0]    out_peak_reg, out_floor_reg, out_avg_reg;
    logic [DBO_W-1:0] out_dbp_reg, out_dba_reg;
    logic [S_W-1:0]   out_sp_reg, out_sa_reg;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_count_reg <= '0;
            ref_db_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SKIP_COUNT: skip_count_reg <= cfg_data;
                CFG_REF_DB:     ref_db_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Ready chain: a stage takes new data when empty or moving on.
    // ------------------------------------------------------------------
    assign rdy_out  = !out_valid_reg || m_tready;
    assign rdy6     = !st6_valid_reg || rdy_out;
    assign rdy5     = !st5_valid_reg || rdy6;
    assign rdy4     = !st4_valid_reg || rdy5;
    assign rdy3     = !st3_valid_reg || rdy4;
    assign rdy2     = !st2_valid_reg || rdy3;
    assign rdy1     = !st1_valid_reg || rdy2;
    assign s_tready = !in_valid_reg || rdy1;
    assign fire_a   = in_valid_reg && rdy1;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            in_last_reg   <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Per-sample state update and ring update at a measured block end
    // ------------------------------------------------------------------

    // Saturating magnitude: only the most negative sample reaches bit LW.
    assign mag_raw   = in_sample_reg[SAMPLE_BITS-1] ? (~in_sample_reg + 1'b1)
                                                    : in_sample_reg;
    assign mag       = mag_raw[SAMPLE_BITS-1] ? FULL_SCALE : mag_raw[LW-1:0];
    assign blk_peak  = (mag > running_peak_reg) ? mag : running_peak_reg;
    assign blk_floor = (mag < running_floor_reg) ? mag : running_floor_reg;
    assign ring_old  = ring_valid_reg[ring_pos_reg] ? ram_rd_data : '0;

    always_comb begin
        running_peak_next  = running_peak_reg;
        running_floor_next = running_floor_reg;
        block_counter_next = block_counter_reg;
        ring_valid_next    = ring_valid_reg;
        ring_pos_next      = ring_pos_reg;
        ring_sum_next      = ring_sum_reg;
        ram_wr_en          = 1'b0;
        meas_evt           = 1'b0;
        if (fire_a) begin
            if (!in_last_reg) begin
                running_peak_next  = blk_peak;
                running_floor_next = blk_floor;
            end else begin
                running_peak_next  = '0;
                running_floor_next = FULL_SCALE;
                if (block_counter_reg < skip_count_reg) begin
                    block_counter_next = block_counter_reg + 1'b1;
                end else begin
                    block_counter_next           = '0;
                    meas_evt                     = 1'b1;
                    ram_wr_en                    = 1'b1;
                    ring_sum_next                = ring_sum_reg - SUM_W'(ring_old)
                                                   + SUM_W'(blk_peak);
                    ring_valid_next[ring_pos_reg] = 1'b1;
                    ring_pos_next = (ring_pos_reg == POS_LAST) ? '0
                                                               : ring_pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_peak_reg  <= '0;
            running_floor_reg <= FULL_SCALE;
            block_counter_reg <= '0;
            ring_valid_reg    <= '0;
            ring_pos_reg      <= '0;
            ring_sum_reg      <= '0;
        end else begin
            running_peak_reg  <= running_peak_next;
            running_floor_reg <= running_floor_next;
            block_counter_reg <= block_counter_next;
            ring_valid_reg    <= ring_valid_next;
            ring_pos_reg      <= ring_pos_next;
            ring_sum_reg      <= ring_sum_next;
        end
    end

    // Ring of block peaks. The read address follows the next position so
    // the entry to be replaced is already registered at the next block end.
    bslm_ram #(
        .WIDTH (LW),
        .DEPTH (AVG_LEN)
    ) u_peak_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ring_pos_reg),
        .wr_data (blk_peak),
        .rd_addr (ring_pos_next),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Result pipeline
    // ------------------------------------------------------------------

    // Stage 2 inputs: partial products of the ring sum and the reciprocal.
    assign st2_pp_lo_next = PLO_W'(st1_sum_reg) * PLO_W'(AVG_M_LO);
    assign st2_pp_hi_next = PHI_W'(st1_sum_reg) * PHI_W'(AVG_M_HI);

    // Stage 3 inputs: recombined product gives the truncated ring mean.
    assign avg_total    = (PTOT_W'(st2_pp_hi_reg) << AVG_H) + PTOT_W'(st2_pp_lo_reg);
    assign st3_avg_next = avg_total[AVG_K +: LW];

    // Stage 4 inputs: levels scaled to the 1..508 range.
    assign st4_xp_next = lvl_to_x(st3_peak_reg);
    assign st4_xa_next = lvl_to_x(st3_avg_reg);

    // Stage 5 inputs: log2 in Q20.
    assign st5_lp_next = x_log2(st4_xp_reg);
    assign st5_la_next = x_log2(st4_xa_reg);

    // Stage 6 inputs: Q4 dB, rounded half up.
    assign db_prod_p    = PROD_W'(st5_lp_reg) * PROD_W'(DB_COEF) + DB_ROUND;
    assign db_prod_a    = PROD_W'(st5_la_reg) * PROD_W'(DB_COEF) + DB_ROUND;
    assign st6_dbp_next = db_prod_p[DB_SHIFT +: DB_W];
    assign st6_dba_next = db_prod_a[DB_SHIFT +: DB_W];

    // Output inputs: S values and dB with the reference taken off.
    assign s_prod_p     = S_PROD_W'(st6_dbp_reg) * S_PROD_W'(S_RECIP);
    assign s_prod_a     = S_PROD_W'(st6_dba_reg) * S_PROD_W'(S_RECIP);
    assign out_sp_next  = s_prod_p[S_SHIFT +: S_W];
    assign out_sa_next  = s_prod_a[S_SHIFT +: S_W];
    assign ref_q4       = {ref_db_reg[CFG_DATA_W-1], ref_db_reg, 4'b0000};
    assign out_dbp_next = DBO_W'(st6_dbp_reg) - ref_q4;
    assign out_dba_next = DBO_W'(st6_dba_reg) - ref_q4;

    // Pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
            st6_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                st1_valid_reg <= meas_evt;
            end
            if (rdy2) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (rdy3) begin
                st3_valid_reg <= st2_valid_reg;
            end
            if (rdy4) begin
                st4_valid_reg <= st3_valid_reg;
            end
            if (rdy5) begin
                st5_valid_reg <= st4_valid_reg;
            end
            if (rdy6) begin
                st6_valid_reg <= st5_valid_reg;
            end
            if (rdy_out) begin
                out_valid_reg <= st6_valid_reg;
            end
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            st1_peak_reg  <= blk_peak;
            st1_floor_reg <= blk_floor;
            st1_sum_reg   <= ring_sum_next;
        end
        if (rdy2) begin
            st2_peak_reg  <= st1_peak_reg;
            st2_floor_reg <= st1_floor_reg;
            st2_pp_lo_reg <= st2_pp_lo_next;
            st2_pp_hi_reg <= st2_pp_hi_next;
        end
        if (rdy3) begin
            st3_peak_reg  <= st2_peak_reg;
            st3_floor_reg <= st2_floor_reg;
            st3_avg_reg   <= st3_avg_next;
        end
        if (rdy4) begin
            st4_peak_reg  <= st3_peak_reg;
            st4_floor_reg <= st3_floor_reg;
            st4_avg_reg   <= st3_avg_reg;
            st4_xp_reg    <= st4_xp_next;
            st4_xa_reg    <= st4_xa_next;
        end
        if (rdy5) begin
            st5_peak_reg  <= st4_peak_reg;
            st5_floor_reg <= st4_floor_reg;
            st5_avg_reg   <= st4_avg_reg;
            st5_lp_reg    <= st5_lp_next;
            st5_la_reg    <= st5_la_next;
        end
        if (rdy6) begin
            st6_peak_reg  <= st5_peak_reg;
            st6_floor_reg <= st5_floor_reg;
            st6_avg_reg   <= st5_avg_reg;
            st6_dbp_reg   <= st6_dbp_next;
            st6_dba_reg   <= st6_dba_next;
        end
        if (rdy_out) begin
            out_peak_reg  <= st6_peak_reg;
            out_floor_reg <= st6_floor_reg;
            out_avg_reg   <= st6_avg_reg;
            out_dbp_reg   <= out_dbp_next;
            out_dba_reg   <= out_dba_next;
            out_sp_reg    <= out_sp_next;
            out_sa_reg    <= out_sa_next;
        end
    end

    // Result channel.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_sa_reg, out_sp_reg, out_dba_reg, out_dbp_reg,
                              out_avg_reg, out_floor_reg, out_peak_reg});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // After a sample inside a block, the floor never exceeds the peak.
    a_floor_below_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire_a && !in_last_reg) |=> (running_floor_reg <= running_peak_reg))
        else $error("running floor above running peak");

    // A measured block end always enters the result pipeline.
    a_event_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        meas_evt |=> st1_valid_reg)
        else $error("measured block end lost before the result pipeline");

    // The ring sum never exceeds the ring length times full scale.
    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_sum_reg <= SUM_MAX)
        else $error("ring sum out of range");

endmodule

### dv/bslm_level_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Block signal level meter checker
// Watches the sample, configuration and result channels of the meter. It
// keeps its own copy of the meter state, predicts one report per measured
// block end, and compares each result transaction field by field.
// ============================================================================
module bslm_level_checker
    import bslm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [15:0]           s_tdata,
    input  logic                  s_tlast,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [87:0]           m_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    reports_waiting,
    output int                    reports_checked
);

    localparam int          HIST_LEN   = 8;
    localparam logic [14:0] FULL_LEVEL = 15'h7FFF;

    // One block report, first field in the lowest bits as on m_tdata.
    typedef struct packed {
        logic [7:0]  average_s;
        logic [7:0]  peak_s;
        logic [12:0] average_db;
        logic [12:0] peak_db;
        logic [14:0] average_level;
        logic [14:0] floor_level;
        logic [14:0] peak_level;
    } level_report_t;

    level_report_t expected_reports[$];

    // Mirror of the meter registers and state.
    logic [7:0]  skip_reg;
    logic [7:0]  ref_reg;
    logic [7:0]  blocks_skipped;
    logic [14:0] blk_peak;
    logic [14:0] blk_floor;
    logic [14:0] peak_hist [HIST_LEN];
    int          hist_pos;
    int unsigned hist_sum;

    initial begin
        fail_count      = 0;
        reports_waiting = 0;
        reports_checked = 0;
    end

    // Q4 dB of a level: 20*log10 of ceil(level*508/FS), with a log2 built from
    // truncated repeated squaring of a Q30 mantissa.
    function automatic logic [9:0] level_to_db_q4(input logic [14:0] lvl);
        logic [63:0] x;
        logic [63:0] m;
        logic [63:0] lg;
        logic [63:0] prod;
        logic [19:0] fr;
        int          n;
        if (lvl == 0)
            x = 64'd1;
        else
            x = (64'(lvl) * 64'd508 + 64'(FULL_LEVEL) - 64'd1) / 64'(FULL_LEVEL);
        if (x < 64'd1) x = 64'd1;
        if (x > 64'd508) x = 64'd508;
        n = 0;
        while ((x >> (n + 1)) != 0) n++;
        m  = x << (30 - n);
        fr = '0;
        for (int i = 0; i < 20; i++) begin
            m  = (m * m) >> 30;
            fr = {fr[18:0], 1'b0};
            if (m >= (64'd2 << 30)) begin
                m     = m >> 1;
                fr[0] = 1'b1;
            end
        end
        lg   = (64'(n) << 20) | 64'(fr);
        prod = (lg * 64'd101008905 + (64'd1 << 39)) >> 40;
        return prod[9:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("report %0d %s got %0d expected %0d",
                                      reports_checked, name, got, want));
    endtask

    task automatic clear_block_levels();
        blk_peak  = '0;
        blk_floor = FULL_LEVEL;
    endtask

    // Meter step for one accepted sample; pushes a report at a measured block end.
    task automatic meter_take_sample(input logic [15:0] smp, input logic lst);
        logic [16:0]   mag;
        logic [14:0]   pk;
        logic [14:0]   fl;
        logic [14:0]   avg;
        logic [9:0]    pdb;
        logic [9:0]    adb;
        int            ref_q4;
        level_report_t rpt;
        mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
        if (mag > 17'(FULL_LEVEL)) mag = 17'(FULL_LEVEL);
        if (mag[14:0] > blk_peak) blk_peak = mag[14:0];
        if (mag[14:0] < blk_floor) blk_floor = mag[14:0];
        if (!lst) return;

        // Skipped block: count it and start over without touching the ring.
        if (blocks_skipped < skip_reg) begin
            blocks_skipped = blocks_skipped + 8'd1;
            clear_block_levels();
            return;
        end
        blocks_skipped = '0;
        pk = blk_peak;
        fl = blk_floor;
        clear_block_levels();

        hist_sum            = hist_sum - peak_hist[hist_pos] + pk;
        peak_hist[hist_pos] = pk;
        hist_pos            = (hist_pos + 1) % HIST_LEN;
        avg                 = 15'(hist_sum / HIST_LEN);

        pdb    = level_to_db_q4(pk);
        adb    = level_to_db_q4(avg);
        ref_q4 = int'($signed(ref_reg)) * 16;

        rpt.peak_level    = pk;
        rpt.floor_level   = fl;
        rpt.average_level = avg;
        rpt.peak_db       = 13'(int'(pdb) - ref_q4);
        rpt.average_db    = 13'(int'(adb) - ref_q4);
        rpt.peak_s        = 8'(pdb / 6);
        rpt.average_s     = 8'(adb / 6);
        expected_reports.push_back(rpt);
    endtask

    // Channel monitor: register writes, samples in, reports out.
    always @(posedge aclk) begin
        level_report_t got;
        level_report_t want;
        if (!aresetn) begin
            skip_reg       = '0;
            ref_reg        = '0;
            blocks_skipped = '0;
            clear_block_levels();
            for (int i = 0; i < HIST_LEN; i++) peak_hist[i] = '0;
            hist_pos = 0;
            hist_sum = 0;
            expected_reports.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SKIP_COUNT: skip_reg = cfg_data;
                    CFG_REF_DB:     ref_reg  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                meter_take_sample(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got = level_report_t'(m_tdata[86:0]);
                if (expected_reports.size() == 0) begin
                    report_mismatch("result transaction with no report expected");
                end else begin
                    want = expected_reports.pop_front();
                    check_field("peak_level", got.peak_level, want.peak_level);
                    check_field("floor_level", got.floor_level, want.floor_level);
                    check_field("average_level", got.average_level, want.average_level);
                    check_field("peak_db", got.peak_db, want.peak_db);
                    check_field("average_db", got.average_db, want.average_db);
                    check_field("peak_s", got.peak_s, want.peak_s);
                    check_field("average_s", got.average_s, want.average_s);
                end
                reports_checked++;
            end
        end
        reports_waiting = expected_reports.size();
    end

endmodule

### dv/block_signal_level_meter_top_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Block signal level meter testbench
// Drives sample blocks and register writes into the meter under random
// backpressure and gaps, with a checker beside it that predicts and compares
// every block report. Directed blocks come first, then random phases.
// ============================================================================
module block_signal_level_meter_top_test
    import bslm_pkg::*;
();

    localparam int LATENCY_WAIT = 20;
    localparam int LONG_HOLD    = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic [15:0]           s_tdata;
    logic                  s_tlast;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [87:0]           m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int reports_waiting;
    int reports_checked;
    int samples_sent;
    int reg_writes;
    bit tx_idle;
    bit rx_idle;
    bit hold_off_req;

    always #1 aclk = ~aclk;

    block_signal_level_meter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bslm_level_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .reports_waiting (reports_waiting),
        .reports_checked (reports_checked)
    );

    // Run limit, well above the slowest legal run.
    initial begin
        #1_000_000;
        $display("block_signal_level_meter_top_test: FAIL");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_off_req = 1'b0;
                m_tready <= 1'b1;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one sample, with an optional gap first, and wait for its transaction.
    task automatic put_sample(input logic [15:0] smp, input logic lst);
        if (tx_idle && $urandom_range(0, 6) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tdata  <= smp;
        s_tlast  <= lst;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    // Stop offering samples until every report is in and the pipeline is empty.
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (reports_waiting != 0);
        repeat (LATENCY_WAIT) @(posedge aclk);
    endtask

    task automatic cfg_transfer(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        reg_writes++;
    endtask

    // Write both registers, sometimes with an unused index in between.
    task automatic write_regs(input logic [7:0] skip_v, input logic [7:0] ref_v);
        cfg_transfer(CFG_SKIP_COUNT, skip_v);
        if ($urandom_range(0, 1) == 1)
            cfg_transfer(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
        cfg_transfer(CFG_REF_DB, ref_v);
        cfg_valid <= 1'b0;
    endtask

    // Mix of full-scale corners, raw random words and sign-extended small levels.
    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 5))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = 16'h0000;
                    3:       v = 16'h0001;
                    4:       v = 16'hFFFF;
                    default: v = 16'h8001;
                endcase
            end
            1, 2: v = 16'($urandom);
            default: begin
                v = 16'($urandom_range(0, 32767) >> $urandom_range(0, 14));
                if ($urandom_range(0, 1) == 1) v = -v;
            end
        endcase
        return v;
    endfunction

    // Random blocks: mostly short, now and then up to max_len samples.
    task automatic send_blocks(input int n_items, input int max_len);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, max_len)
                                              : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                put_sample(pick_sample(), i == len - 1);
            sent += len;
        end
    endtask

    task automatic run_phase(input logic [7:0] skip_v, input logic [7:0] ref_v,
                             input int n_items, input int max_len);
        drain_reports();
        write_regs(skip_v, ref_v);
        send_blocks(n_items, max_len);
    endtask

    initial begin
        samples_sent = 0;
        reg_writes   = 0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        hold_off_req = 1'b0;
        aresetn   <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: one-sample blocks at zero and the full-scale corners,
        // including the most negative sample, then two multi-sample blocks and
        // a one-sample block, so that the peak ring wraps.
        put_sample(16'h0000, 1'b1);
        put_sample(16'h7FFF, 1'b1);
        put_sample(16'h8000, 1'b1);
        put_sample(16'h8001, 1'b1);
        put_sample(16'h0001, 1'b1);
        put_sample(16'hFFFF, 1'b1);
        put_sample(16'd3, 1'b0);
        put_sample(16'hFFFB, 1'b0);
        put_sample(16'd100, 1'b1);
        put_sample(16'h4000, 1'b0);
        put_sample(16'hC000, 1'b1);
        put_sample(16'hFFFE, 1'b1);

        // Skipped blocks around one measured block, lowest reference.
        drain_reports();
        write_regs(8'd2, 8'h80);
        repeat (4) put_sample(16'd777, 1'b1);

        // Raise the skip count, skip three blocks, then lower it below the
        // block count so that the next block is measured at once.
        drain_reports();
        write_regs(8'd5, 8'h7F);
        repeat (3) put_sample(16'hF000, 1'b1);
        drain_reports();
        write_regs(8'd1, 8'h7F);
        put_sample(16'd12345, 1'b1);
        put_sample(16'hB1E0, 1'b0);
        put_sample(16'd7, 1'b1);
        put_sample(16'd9, 1'b0);
        put_sample(16'h8AD0, 1'b1);

        // Random phases across the register ranges.
        run_phase(8'd0, 8'($urandom), 80, 40);
        run_phase(8'($urandom_range(1, 3)), 8'h80, 70, 24);
        drain_reports();
        write_regs(8'd255, 8'h7F);
        repeat (260) put_sample(pick_sample(), 1'b1);

        // Long result stall while one-sample blocks keep coming.
        drain_reports();
        write_regs(8'd0, 8'($urandom));
        hold_off_req = 1'b1;
        repeat (60) put_sample(pick_sample(), 1'b1);

        run_phase(8'($urandom_range(0, 1)), 8'($urandom), 60, 16);

        // Last part at full rate on both sides.
        drain_reports();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        write_regs(8'd0, 8'd0);
        send_blocks(80, 12);
        drain_reports();

        $display("Run covered %0d samples, %0d block reports and %0d register writes.",
                 samples_sent, reports_checked, reg_writes);
        $display("Skip counts ran from 0 to 255 and references from -128 to 127 dB.");
        if (fail_count == 0 && reports_waiting == 0)
            $display("block_signal_level_meter_top_test: PASS");
        else
            $display("block_signal_level_meter_top_test: FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/bslm_pkg.sv
rtl/bslm_ram.sv
rtl/block_signal_level_meter_top.sv
dv/bslm_level_checker.sv
dv/block_signal_level_meter_top_test.sv
